### hdl/grn_pkg.sv
// Shared types, operation codes and controller command/status structs for the graph navigator.
package grn_pkg;

	// Default graph size
	localparam int MAX_NODES_DEF = 16;

	// Node handle as carried on the ports
	localparam int NODE_W = 4;
	typedef logic [NODE_W-1:0] node_t;

	// Operation codes
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_LINK   = 2'd1;
	localparam logic [1:0] OP_SETCUR = 2'd2;
	localparam logic [1:0] OP_CHECK  = 2'd3;

	// Row read address select
	localparam logic [1:0] RD_A    = 2'd0;
	localparam logic [1:0] RD_B    = 2'd1;
	localparam logic [1:0] RD_CUR  = 2'd2;
	localparam logic [1:0] RD_PICK = 2'd3;

	// Row write select
	localparam logic WR_A = 1'b0;
	localparam logic WR_B = 1'b1;

	// Request transaction
	typedef struct packed {
		logic [1:0] op;
		node_t      node_a;
		node_t      node_b;
		logic       both_ways;
	} grn_req_t;

	// Response transaction
	typedef struct packed {
		logic  status;
		node_t new_handle;
		node_t current_node;
		logic  has_current;
		logic  connected;
	} grn_rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic       wr_sel;
		logic       create;
		logic       set_cur;
		logic       reach_init;
		logic       reach_run;
		logic       emit;
	} grn_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       both_ways;
		logic       reach_done;
	} grn_stat_t;

endpackage

### hdl/grn_ctrl.sv
// Controller state machine sequencing each operation through the datapath.
module grn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  grn_pkg::grn_stat_t  stat,
	output grn_pkg::grn_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_LNK_WA = 3'd2;
	localparam logic [2:0] ST_LNK_RB = 3'd3;
	localparam logic [2:0] ST_LNK_WB = 3'd4;
	localparam logic [2:0] ST_SET    = 3'd5;
	localparam logic [2:0] ST_CHK    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	// Decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.op)
					grn_pkg::OP_CREATE: begin
						cmd.create = 1'b1;
						cmd.emit   = 1'b1;
						state_d    = ST_IDLE;
					end
					grn_pkg::OP_LINK: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = grn_pkg::RD_A;
						state_d    = ST_LNK_WA;
					end
					grn_pkg::OP_SETCUR: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = grn_pkg::RD_CUR;
						state_d    = ST_SET;
					end
					default: begin
						cmd.reach_init = 1'b1;
						state_d        = ST_CHK;
					end
				endcase
			end
			ST_LNK_WA: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = grn_pkg::WR_A;
				if (stat.both_ways) begin
					state_d = ST_LNK_RB;
				end else begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_LNK_RB: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = grn_pkg::RD_B;
				state_d    = ST_LNK_WB;
			end
			ST_LNK_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = grn_pkg::WR_B;
				cmd.emit   = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SET: begin
				cmd.set_cur = 1'b1;
				cmd.emit    = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_CHK: begin
				if (stat.reach_done) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = grn_pkg::RD_PICK;
					cmd.reach_run = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/grn_dpath.sv
// Datapath: adjacency row memory, node count, current node, reachable-set search, response.
module grn_dpath #(
	parameter int MAX_NODES = grn_pkg::MAX_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  grn_pkg::grn_req_t   req,
	input  grn_pkg::grn_cmd_t   cmd,
	output grn_pkg::grn_stat_t  stat,
	output logic                done,
	output grn_pkg::grn_rsp_t   rsp
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int WW = (CW > grn_pkg::NODE_W) ? CW : grn_pkg::NODE_W;

	// Adjacency memory and per-row valid bits
	logic [MAX_NODES-1:0] mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_vld_q;

	grn_pkg::grn_req_t    req_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        cur_idx_q;
	logic                 cur_vld_q;
	logic [MAX_NODES-1:0] reach_q;
	logic [MAX_NODES-1:0] expanded_q;
	logic [MAX_NODES-1:0] rd_row_s1;
	logic                 rd_vld_s1;
	logic                 inflight_s1;
	logic                 done_q;
	grn_pkg::grn_rsp_t    rsp_q;

	logic [AW-1:0]        a_idx;
	logic [AW-1:0]        b_idx;
	logic                 a_ok;
	logic                 b_ok;
	logic                 link_ok;
	logic                 full;
	logic                 set_ok;
	logic [MAX_NODES-1:0] rd_row;
	logic [MAX_NODES-1:0] pending;
	logic                 any_pending;
	logic [AW-1:0]        pick;
	logic [AW-1:0]        rd_addr;
	logic                 rd_issue;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        wr_bit;
	logic [MAX_NODES-1:0] wr_row;
	logic                 wr_do;
	logic [MAX_NODES-1:0] count_mask;
	logic [AW-1:0]        cur_idx_d;
	logic                 cur_vld_d;
	grn_pkg::grn_rsp_t    rsp_d;

	// Range checks against the created node count
	assign a_idx   = AW'(req_q.node_a);
	assign b_idx   = AW'(req_q.node_b);
	assign a_ok    = (WW'(req_q.node_a) < WW'(count_q));
	assign b_ok    = (WW'(req_q.node_b) < WW'(count_q));
	assign link_ok = a_ok && b_ok;
	assign full    = (count_q == CW'(MAX_NODES));

	// Unwritten rows read as zero
	assign rd_row = rd_vld_s1 ? rd_row_s1 : '0;
	assign set_ok = a_ok && (!cur_vld_q || rd_row[a_idx]);

	// Pick lowest reached node not yet expanded
	assign pending     = reach_q & ~expanded_q;
	assign any_pending = |pending;
	always_comb begin
		pick = '0;
		for (int j = MAX_NODES - 1; j >= 0; j--) begin
			if (pending[j]) pick = AW'(j);
		end
	end

	// Select read address
	always_comb begin
		case (cmd.rd_sel)
			grn_pkg::RD_A:   rd_addr = a_idx;
			grn_pkg::RD_B:   rd_addr = b_idx;
			grn_pkg::RD_CUR: rd_addr = cur_idx_q;
			default:         rd_addr = pick;
		endcase
	end
	assign rd_issue = cmd.rd_en && ((cmd.rd_sel != grn_pkg::RD_PICK) || any_pending);

	// Merge one edge into the row just read
	assign wr_addr = (cmd.wr_sel == grn_pkg::WR_B) ? b_idx : a_idx;
	assign wr_bit  = (cmd.wr_sel == grn_pkg::WR_B) ? a_idx : b_idx;
	assign wr_row  = rd_row | (MAX_NODES'(1) << wr_bit);
	assign wr_do   = cmd.wr_en && link_ok;

	// Mask of created nodes
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			count_mask[j] = (CW'(j) < count_q);
		end
	end

	// Current node after this operation
	always_comb begin
		cur_idx_d = cur_idx_q;
		cur_vld_d = cur_vld_q;
		if (cmd.set_cur && set_ok) begin
			cur_idx_d = a_idx;
			cur_vld_d = 1'b1;
		end
	end

	// Build response
	always_comb begin
		rsp_d              = '0;
		rsp_d.current_node = grn_pkg::node_t'(cur_idx_d);
		rsp_d.has_current  = cur_vld_d;
		case (req_q.op)
			grn_pkg::OP_CREATE: begin
				rsp_d.status     = full;
				rsp_d.new_handle = full ? '0 : grn_pkg::node_t'(count_q);
			end
			grn_pkg::OP_LINK:   rsp_d.status = !link_ok;
			grn_pkg::OP_SETCUR: rsp_d.status = !set_ok;
			default: begin
				rsp_d.connected = cur_vld_q && (reach_q == count_mask);
			end
		endcase
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_do) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_issue) begin
			rd_row_s1 <= mem[rd_addr];
		end
	end

	// Hold the request and the response payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	// Advance graph state and reachable-set search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q   <= '0;
			rd_vld_s1   <= 1'b0;
			count_q     <= '0;
			cur_idx_q   <= '0;
			cur_vld_q   <= 1'b0;
			reach_q     <= '0;
			expanded_q  <= '0;
			inflight_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q    <= cmd.emit;
			cur_idx_q <= cur_idx_d;
			cur_vld_q <= cur_vld_d;
			if (wr_do) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_issue) begin
				rd_vld_s1 <= row_vld_q[rd_addr];
			end
			if (cmd.create && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.reach_init) begin
				reach_q     <= MAX_NODES'(1) << cur_idx_q;
				expanded_q  <= '0;
				inflight_s1 <= 1'b0;
			end else if (cmd.reach_run) begin
				if (inflight_s1) begin
					reach_q <= reach_q | rd_row;
				end
				if (any_pending) begin
					expanded_q[pick] <= 1'b1;
				end
				inflight_s1 <= any_pending;
			end
		end
	end

	assign stat.op         = req_q.op;
	assign stat.both_ways  = req_q.both_ways;
	assign stat.reach_done = !any_pending && !inflight_s1;

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hdl/graph_reachability_navigator.sv
// Top level of the graph navigator: controller plus datapath.
//
// Usage: drive req and raise start; the transaction is taken at a rising edge with
// start high and busy low. busy stays high until the response has been produced.
// One response follows each request: done is high for exactly one cycle with rsp
// valid, and the receiver must take it then, as it cannot hold responses off.
// A new request may be taken in the cycle in which done is high.
// Create completes at decode; set current first reads the current node's row;
// link reads and rewrites the row of node_a, and with both_ways set that of node_b.
// The check time is set by the reachable-set search: each reached node has its
// adjacency row read from the row memory once, one row per cycle, and a node found
// only through the row just read waits for that row to be merged, so the time
// grows with the number of nodes reachable from the current node.
// Link and set current are read-modify-write or lookups on the row memory, which
// has one read port and a separate write port.
// Reset (arst_n low) clears the node count, the current node and the row valid
// bits, so every row reads as having no edges; no clearing pass is needed and a
// request can be taken as soon as reset is released.
module graph_reachability_navigator #(
	parameter int MAX_NODES = grn_pkg::MAX_NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  grn_pkg::grn_req_t  req,
	output logic               busy,
	output logic               done,
	output grn_pkg::grn_rsp_t  rsp
);

	grn_pkg::grn_cmd_t  cmd;
	grn_pkg::grn_stat_t stat;

	// Sequence operations
	grn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Hold graph state and compute results
	grn_dpath #(
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
